// ----- rtl/page_framebuffer_raster_blit_top_defines.svh -----
// Assertion macros for the page framebuffer raster blitter.
`ifndef PAGE_FRAMEBUFFER_RASTER_BLIT_TOP_DEFINES_SVH
`define PAGE_FRAMEBUFFER_RASTER_BLIT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, quiet during rst.
`define PFB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfb assertion failed");
// Next-cycle implication, sampled on clk, quiet during rst.
`define PFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfb assertion failed");
`else
`define PFB_ASSERT_IMPL(lbl, ante, cons)
`define PFB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/pfb_pkg.sv -----
// Shared types and constants of the page framebuffer raster blitter.
package pfb_pkg;

  // Store size in bytes and the address width that follows from it.
  localparam int FRAME_BYTES = 1024;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);

  // Width of a display position (offset plus image coordinate).
  localparam int POS_W = 13;

  // Longest raster row in bytes.
  localparam logic [9:0] ROW_BYTES_CAP = 10'd512;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_IMAGE = 2'd1,
    CMD_SET   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    REG_DISP_WIDTH  = 3'd0,
    REG_DISP_HEIGHT = 3'd1,
    REG_IMAGE_COLS  = 3'd2,
    REG_IMAGE_ROWS  = 3'd3,
    REG_ROW_BYTES   = 3'd4,
    REG_ORIGIN_X    = 3'd5,
    REG_ORIGIN_Y    = 3'd6
  } reg_e_t;

  typedef struct packed {
    logic [7:0]  disp_width;
    logic [6:0]  disp_height;
    logic [11:0] image_cols;
    logic [11:0] image_rows;
    logic [9:0]  row_bytes;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
  } pix_t;

  typedef struct packed {
    logic [7:0] data;
    logic       done;
  } res_t;

endpackage

// ----- rtl/pfb_frame_mem.sv -----
// Single-port frame store with registered read data.
module pfb_frame_mem (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      we,
  input  logic [pfb_pkg::ADDR_W-1:0] addr,
  input  logic [7:0]                wdata,
  output logic [7:0]                rdata
);

  logic [7:0] mem [pfb_pkg::FRAME_BYTES];

  // Write or read one byte per cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/pfb_pix_addr.sv -----
// Shared pixel unit: clip a display position and map it to a page byte and bit.
module pfb_pix_addr (
  input  logic [pfb_pkg::POS_W-1:0] x,
  input  logic [pfb_pkg::POS_W-1:0] y,
  input  logic [7:0]                disp_width,
  input  logic [6:0]                disp_height,
  output pfb_pkg::pix_t             pix
);

  logic                      in_disp;
  logic [11:0]               page_base;
  logic [pfb_pkg::POS_W-1:0] idx;

  // Clip against the display, then index = x + width * page.
  always_comb begin
    in_disp   = (x < pfb_pkg::POS_W'(disp_width)) && (y < pfb_pkg::POS_W'(disp_height));
    page_base = 12'(disp_width) * 12'(y[6:3]);
    idx       = pfb_pkg::POS_W'(x[7:0]) + pfb_pkg::POS_W'(page_base);
    pix.hit   = in_disp && (32'(idx) < pfb_pkg::FRAME_BYTES);
    pix.addr  = pfb_pkg::ADDR_W'(idx);
    pix.mask  = 8'(8'd1 << y[2:0]);
  end

endmodule

// ----- rtl/pfb_ctrl.sv -----
// Command sequencer: clear sweep, per-pixel read-modify-write, reads, raster position.
module pfb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  pfb_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_cmd,
  input  logic [7:0]    in_data,
  input  logic [11:0]   in_x,
  input  logic [11:0]   in_y,
  input  logic [9:0]    in_ridx,
  input  logic          out_free,
  output logic          res_valid,
  output pfb_pkg::res_t res
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_PIX   = 6'b000100,
    ST_MOD   = 6'b001000,
    ST_RD    = 6'b010000,
    ST_RES   = 6'b100000
  } state_t;

  state_t state, state_next;

  pfb_pkg::cmd_e_t            cmd_q;
  logic [7:0]                 data_q;
  logic [11:0]                px_q;
  logic [11:0]                py_q;
  logic [pfb_pkg::ADDR_W-1:0] ridx_q;
  logic                       rd_ok_q;
  logic                       done_q;
  logic [2:0]                 bit_cnt;
  logic [pfb_pkg::ADDR_W-1:0] sweep;
  logic [pfb_pkg::ADDR_W-1:0] addr_q;
  logic [7:0]                 mask_q;
  logic [11:0]                raster_row;
  logic [8:0]                 raster_pos;

  logic [11:0]               col;
  logic [pfb_pkg::POS_W-1:0] x_src;
  logic [pfb_pkg::POS_W-1:0] y_src;
  logic                      lit;
  logic                      plot;
  logic                      last_pix;
  logic                      advance;
  logic                      finish;
  logic [9:0]                row_len;
  logic                      row_end;
  logic                      img_last;
  logic                      past_img;
  pfb_pkg::pix_t             pix;

  logic                       mem_en;
  logic                       mem_we;
  logic [pfb_pkg::ADDR_W-1:0] mem_addr;
  logic [7:0]                 mem_wdata;
  logic [7:0]                 mem_rdata;

  // Select the pixel under work: raster bit or single set-pixel point.
  always_comb begin
    col = {raster_pos, 3'b000} + 12'(bit_cnt);
    if (cmd_q == pfb_pkg::CMD_IMAGE) begin
      x_src = pfb_pkg::POS_W'(cfg.origin_x) + pfb_pkg::POS_W'(col);
      y_src = pfb_pkg::POS_W'(cfg.origin_y) + pfb_pkg::POS_W'(raster_row);
      lit   = data_q[3'd7 - bit_cnt] && (col < cfg.image_cols);
    end else begin
      x_src = pfb_pkg::POS_W'(px_q);
      y_src = pfb_pkg::POS_W'(py_q);
      lit   = 1'b1;
    end
  end

  pfb_pix_addr u_pix_addr (
    .x           (x_src),
    .y           (y_src),
    .disp_width  (cfg.disp_width),
    .disp_height (cfg.disp_height),
    .pix         (pix)
  );

  // Raster row bookkeeping.
  always_comb begin
    if (cfg.row_bytes == 10'd0) begin
      row_len = 10'd1;
    end else if (cfg.row_bytes > pfb_pkg::ROW_BYTES_CAP) begin
      row_len = pfb_pkg::ROW_BYTES_CAP;
    end else begin
      row_len = cfg.row_bytes;
    end
    row_end  = (10'(raster_pos) + 10'd1) >= row_len;
    img_last = (13'(raster_row) + 13'd1) >= 13'(cfg.image_rows);
    past_img = raster_row >= cfg.image_rows;
  end

  // Step through the eight bits of an image byte; a plotted pixel adds a write step.
  always_comb begin
    plot     = (state == ST_PIX) && lit && pix.hit;
    last_pix = (cmd_q != pfb_pkg::CMD_IMAGE) || (bit_cnt == 3'd7);
    advance  = ((state == ST_PIX) && !plot && !last_pix) ||
               ((state == ST_MOD) && !last_pix);
    finish   = ((state == ST_PIX) && !plot && last_pix) ||
               ((state == ST_MOD) && last_pix);
  end

  // Drive the store port.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = 8'd0;
    case (state)
      ST_CLEAR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = sweep;
      end
      ST_RD: begin
        mem_en   = 1'b1;
        mem_addr = ridx_q;
      end
      ST_PIX: begin
        mem_en   = plot;
        mem_addr = pix.addr;
      end
      ST_MOD: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = mem_rdata | mask_q;
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  pfb_frame_mem u_frame_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (pfb_pkg::cmd_e_t'(in_cmd))
            pfb_pkg::CMD_CLEAR: state_next = ST_CLEAR;
            pfb_pkg::CMD_IMAGE: state_next = past_img ? ST_RES : ST_PIX;
            pfb_pkg::CMD_SET:   state_next = ST_PIX;
            default:            state_next = ST_RD;
          endcase
        end
      end
      ST_CLEAR: begin
        if (sweep == pfb_pkg::ADDR_W'(pfb_pkg::FRAME_BYTES - 1)) begin
          state_next = ST_RES;
        end
      end
      ST_PIX: begin
        if (plot) begin
          state_next = ST_MOD;
        end else if (last_pix) begin
          state_next = ST_RES;
        end
      end
      ST_MOD: begin
        state_next = last_pix ? ST_RES : ST_PIX;
      end
      ST_RD: begin
        state_next = ST_RES;
      end
      ST_RES: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold the command, walk counters, advance the raster position.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      raster_row <= 12'd0;
      raster_pos <= 9'd0;
    end else begin
      state <= state_next;
      if ((state == ST_IDLE) && in_valid) begin
        cmd_q   <= pfb_pkg::cmd_e_t'(in_cmd);
        data_q  <= in_data;
        px_q    <= in_x;
        py_q    <= in_y;
        ridx_q  <= pfb_pkg::ADDR_W'(in_ridx);
        rd_ok_q <= 32'(in_ridx) < pfb_pkg::FRAME_BYTES;
        done_q  <= 1'b0;
        bit_cnt <= 3'd0;
        sweep   <= '0;
        if ((pfb_pkg::cmd_e_t'(in_cmd) == pfb_pkg::CMD_CLEAR) ||
            ((pfb_pkg::cmd_e_t'(in_cmd) == pfb_pkg::CMD_IMAGE) && past_img)) begin
          raster_row <= 12'd0;
          raster_pos <= 9'd0;
        end
      end
      if (state == ST_CLEAR) begin
        sweep <= sweep + pfb_pkg::ADDR_W'(1);
      end
      if (plot) begin
        addr_q <= pix.addr;
        mask_q <= pix.mask;
      end
      if (advance) begin
        bit_cnt <= bit_cnt + 3'd1;
      end
      if (finish && (cmd_q == pfb_pkg::CMD_IMAGE)) begin
        if (!row_end) begin
          raster_pos <= raster_pos + 9'd1;
        end else begin
          raster_pos <= 9'd0;
          if (img_last) begin
            raster_row <= 12'd0;
            done_q     <= 1'b1;
          end else begin
            raster_row <= raster_row + 12'd1;
          end
        end
      end
    end
  end

  // Hand the result over once the output register is free.
  always_comb begin
    in_ready  = (state == ST_IDLE) && !rst;
    res_valid = (state == ST_RES) && out_free;
    res.data  = ((cmd_q == pfb_pkg::CMD_READ) && rd_ok_q) ? mem_rdata : 8'd0;
    res.done  = done_q;
  end

endmodule

// ----- rtl/page_framebuffer_raster_blit_top.sv -----
// Top level of the page framebuffer raster blitter: ports, registers, output stage.
//
//  channel  | direction | payload
//  s_axis   | in        | tuser = cmd; tdata = data_byte, pixel_x, pixel_y, read_index
//  m_axis   | out       | tdata = read_data; tlast = image_done
//  cfg      | in        | cfg_index selects the register, cfg_data is the value
//
// One item at a time; the single-port store's read-modify-write per plotted pixel sets
// the pace. An image byte steps through its eight bits, with a write step per plotted
// pixel; a byte past the image goes straight to its result. Clear sweeps the whole store.
// Reset clears control state only; the store holds garbage until a clear.
// The output register lets the next transaction in while a result waits on m_axis.
`include "page_framebuffer_raster_blit_top_defines.svh"

module page_framebuffer_raster_blit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // data_byte[7:0], pixel_x[19:8], pixel_y[31:20],
                                     // read_index[41:32], zero pad[47:42]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // read_data[7:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  pfb_pkg::cfg_t cfg;
  pfb_pkg::res_t res;
  logic          res_valid;
  logic          out_free;

  // Take register writes whenever out of reset.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disp_width  <= 8'd128;
      cfg.disp_height <= 7'd64;
      cfg.image_cols  <= 12'd128;
      cfg.image_rows  <= 12'd64;
      cfg.row_bytes   <= 10'd16;
      cfg.origin_x    <= 12'd0;
      cfg.origin_y    <= 12'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (pfb_pkg::reg_e_t'(cfg_index))
        pfb_pkg::REG_DISP_WIDTH:  cfg.disp_width  <= cfg_data[7:0];
        pfb_pkg::REG_DISP_HEIGHT: cfg.disp_height <= cfg_data[6:0];
        pfb_pkg::REG_IMAGE_COLS:  cfg.image_cols  <= cfg_data;
        pfb_pkg::REG_IMAGE_ROWS:  cfg.image_rows  <= cfg_data;
        pfb_pkg::REG_ROW_BYTES:   cfg.row_bytes   <= cfg_data[9:0];
        pfb_pkg::REG_ORIGIN_X:    cfg.origin_x    <= cfg_data;
        pfb_pkg::REG_ORIGIN_Y:    cfg.origin_y    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tuser),
    .in_data   (s_axis_tdata[7:0]),
    .in_x      (s_axis_tdata[19:8]),
    .in_y      (s_axis_tdata[31:20]),
    .in_ridx   (s_axis_tdata[41:32]),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: load a result, drop it once the transaction completes.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_axis_tdata <= res.data;
      m_axis_tlast <= res.done;
    end
  end

  // One command in flight: an accepted transaction drops ready for the next cycle.
  `PFB_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A result is handed over only into a free output register.
  `PFB_ASSERT_IMPL(a_load_free, res_valid, !m_axis_tvalid || m_axis_tready)
  // The end-of-image flag only comes with an image byte, never with read data.
  `PFB_ASSERT_IMPL(a_done_no_data, m_axis_tvalid && m_axis_tlast, m_axis_tdata == 8'd0)

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the page framebuffer raster blitter.
`timescale 1ns / 1ps

import pfb_pkg::*;

// Tracks framebuffer contents and raster position, and checks each reply in order.
class pfb_scoreboard;
  bit [7:0]  disp_w;
  bit [6:0]  disp_h;
  bit [11:0] img_w;
  bit [11:0] img_h;
  bit [9:0]  row_len;
  bit [11:0] x_off;
  bit [11:0] y_off;
  bit [7:0]  frame [FRAME_BYTES];
  bit [11:0] raster_row;
  bit [8:0]  raster_pos;
  res_t      reply_queue [$];
  int        mismatches;

  function new();
    disp_w     = 8'd128;
    disp_h     = 7'd64;
    img_w      = 12'd128;
    img_h      = 12'd64;
    row_len    = 10'd16;
    x_off      = 12'd0;
    y_off      = 12'd0;
    raster_row = 12'd0;
    raster_pos = 9'd0;
    mismatches = 0;
    foreach (frame[i]) frame[i] = 8'h00;
  endfunction

  function void write_reg(reg_e_t idx, logic [11:0] v);
    case (idx)
      REG_DISP_WIDTH:  disp_w  = v[7:0];
      REG_DISP_HEIGHT: disp_h  = v[6:0];
      REG_IMAGE_COLS:  img_w   = v;
      REG_IMAGE_ROWS:  img_h   = v;
      REG_ROW_BYTES:   row_len = v[9:0];
      REG_ORIGIN_X:    x_off   = v;
      REG_ORIGIN_Y:    y_off   = v;
      default: ;
    endcase
  endfunction

  // OR one pixel in; drop it when off the display or past the end of the store
  function void plot_pixel(int x, int y);
    int idx;
    if (x >= int'(disp_w) || y >= int'(disp_h)) return;
    idx = x + int'(disp_w) * (y >> 3);
    if (idx >= FRAME_BYTES) return;
    frame[idx] = frame[idx] | 8'(1 << (y & 7));
  endfunction

  // Draw one raster byte at the current position, then advance; returns image_done
  function bit blit_byte(logic [7:0] d);
    int len;
    int col;
    int b;
    if (raster_row >= img_h) begin
      raster_row = 12'd0;
      raster_pos = 9'd0;
      return 1'b0;
    end
    len = int'(row_len);
    if (len == 0) len = 1;
    if (len > int'(ROW_BYTES_CAP)) len = int'(ROW_BYTES_CAP);
    for (b = 0; b < 8; b++) begin
      col = int'(raster_pos) * 8 + b;
      if (col < int'(img_w) && d[7-b])
        plot_pixel(int'(x_off) + col, int'(y_off) + int'(raster_row));
    end
    if (int'(raster_pos) + 1 < len) begin
      raster_pos = raster_pos + 9'd1;
      return 1'b0;
    end
    raster_pos = 9'd0;
    if (int'(raster_row) + 1 >= int'(img_h)) begin
      raster_row = 12'd0;
      return 1'b1;
    end
    raster_row = raster_row + 12'd1;
    return 1'b0;
  endfunction

  function void note_command(cmd_e_t c, logic [7:0] d, logic [11:0] px, logic [11:0] py,
                             logic [9:0] ri);
    res_t r;
    r.data = 8'h00;
    r.done = 1'b0;
    case (c)
      CMD_CLEAR: begin
        foreach (frame[i]) frame[i] = 8'h00;
        raster_row = 12'd0;
        raster_pos = 9'd0;
      end
      CMD_IMAGE: r.done = blit_byte(d);
      CMD_SET:   plot_pixel(int'(px), int'(py));
      default: begin
        if (int'(ri) < FRAME_BYTES) r.data = frame[ri];
      end
    endcase
    reply_queue.push_back(r);
  endfunction

  function void check_reply(logic [7:0] d, logic done);
    res_t want;
    if (reply_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected transaction: read_data %02h image_done %0b", d, done);
      return;
    end
    want = reply_queue.pop_front();
    if (want.data !== d || want.done !== done) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: read_data exp %02h got %02h, image_done exp %0b got %0b",
                 want.data, d, want.done, done);
    end
  endfunction
endclass

module tb_top;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int MAX_GAP       = 30;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  pfb_scoreboard sb = new();

  page_framebuffer_raster_blit_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Drive the output ready: long hold-off first if requested, else random stalls
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every reply transaction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_reply(m_axis_tdata, m_axis_tlast);
  end

  // Offer one command, after a random idle gap; leaves tvalid high on return
  task automatic send_cmd(cmd_e_t c, logic [7:0] d, logic [11:0] px, logic [11:0] py,
                          logic [9:0] ri);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser  = c;
    s_axis_tdata  = {6'd0, ri, py, px, d};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_command(c, d, px, py, ri);
  endtask

  task automatic write_reg(reg_e_t idx, logic [11:0] v);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_geometry(logic [11:0] dw, logic [11:0] dh, logic [11:0] iw,
                               logic [11:0] ih, logic [11:0] rb, logic [11:0] xo,
                               logic [11:0] yo);
    write_reg(REG_DISP_WIDTH, dw);
    write_reg(REG_DISP_HEIGHT, dh);
    write_reg(REG_IMAGE_COLS, iw);
    write_reg(REG_IMAGE_ROWS, ih);
    write_reg(REG_ROW_BYTES, rb);
    write_reg(REG_ORIGIN_X, xo);
    write_reg(REG_ORIGIN_Y, yo);
  endtask

  // Drop valid, wait for all replies, then let the block go quiet
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.reply_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random command mix: mostly raster bytes, with pixels, reads and rare clears
  task automatic random_cmd();
    int          pick;
    int          span;
    cmd_e_t      c;
    logic [7:0]  d;
    logic [11:0] px;
    logic [11:0] py;
    logic [9:0]  ri;
    pick = int'($urandom_range(99));
    d    = 8'($urandom);
    px   = 12'($urandom);
    py   = 12'($urandom);
    ri   = 10'($urandom);
    if (pick < 2) begin
      c = CMD_CLEAR;
    end else if (pick < 52) begin
      c = CMD_IMAGE;
    end else if (pick < 70) begin
      c = CMD_SET;
      if ($urandom_range(9) < 6) begin
        px = 12'($urandom_range(int'(sb.disp_w) + 2));
        py = 12'($urandom_range(int'(sb.disp_h) + 2));
      end
    end else begin
      c = CMD_READ;
      span = int'(sb.disp_w) * (int'(sb.disp_h) >> 3);
      if (span > FRAME_BYTES) span = FRAME_BYTES;
      if (span > 0 && $urandom_range(9) < 7) ri = 10'($urandom_range(span - 1));
    end
    send_cmd(c, d, px, py, ri);
  endtask

  initial begin
    int dw;
    int dh;
    int iw;
    int ih;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 48'd0;
    s_axis_tuser  = CMD_CLEAR;
    cfg_valid     = 1'b0;
    cfg_index     = REG_DISP_WIDTH;
    cfg_data      = 12'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Store is garbage after reset: clear it before anything reads or ORs into it
    send_cmd(CMD_CLEAR, 8'h00, 12'd0, 12'd0, 10'd0);
    send_cmd(CMD_READ, 8'h00, 12'd0, 12'd0, 10'd0);
    send_cmd(CMD_READ, 8'h00, 12'd0, 12'd0, 10'd1023);
    send_cmd(CMD_SET, 8'h00, 12'd0, 12'd0, 10'd0);
    send_cmd(CMD_SET, 8'h00, 12'd127, 12'd63, 10'd0);
    send_cmd(CMD_SET, 8'h00, 12'd128, 12'd5, 10'd0);
    send_cmd(CMD_SET, 8'h00, 12'd3, 12'd64, 10'd0);
    send_cmd(CMD_SET, 8'hFF, 12'd4095, 12'd4095, 10'd1023);
    send_cmd(CMD_READ, 8'h00, 12'd0, 12'd0, 10'd0);
    send_cmd(CMD_READ, 8'h00, 12'd0, 12'd0, 10'd1023);
    settle();

    // Small image near the bottom-right corner, clipped on the right; ends with done
    load_geometry(12'd128, 12'd64, 12'd12, 12'd2, 12'd2, 12'd120, 12'd62);
    send_cmd(CMD_CLEAR, 8'h00, 12'd0, 12'd0, 10'd0);
    send_cmd(CMD_IMAGE, 8'hFF, 12'd0, 12'd0, 10'd0);
    send_cmd(CMD_IMAGE, 8'hFF, 12'd0, 12'd0, 10'd0);
    send_cmd(CMD_IMAGE, 8'hA5, 12'd0, 12'd0, 10'd0);
    send_cmd(CMD_IMAGE, 8'h81, 12'd0, 12'd0, 10'd0);
    send_cmd(CMD_READ, 8'h00, 12'd0, 12'd0, 10'd1016);

    // Shrink the image under a half-drawn raster: the next byte lands past the image
    send_cmd(CMD_IMAGE, 8'h0F, 12'd0, 12'd0, 10'd0);
    send_cmd(CMD_IMAGE, 8'hF0, 12'd0, 12'd0, 10'd0);
    settle();
    write_reg(REG_IMAGE_ROWS, 12'd1);
    send_cmd(CMD_IMAGE, 8'hFF, 12'd0, 12'd0, 10'd0);
    settle();
    write_reg(REG_IMAGE_ROWS, 12'd0);
    send_cmd(CMD_IMAGE, 8'hFF, 12'd0, 12'd0, 10'd0);
    settle();

    // Zero image width, zero row length, and a display taller than the store
    load_geometry(12'd128, 12'd79, 12'd0, 12'd2, 12'd0, 12'd0, 12'd0);
    send_cmd(CMD_IMAGE, 8'hFF, 12'd0, 12'd0, 10'd0);
    send_cmd(CMD_IMAGE, 8'hFF, 12'd0, 12'd0, 10'd0);
    send_cmd(CMD_SET, 8'h00, 12'd5, 12'd70, 10'd0);
    send_cmd(CMD_SET, 8'h00, 12'd5, 12'd63, 10'd0);
    send_cmd(CMD_READ, 8'h00, 12'd0, 12'd0, 10'd901);

    // Random phases, each with its own geometry and idling pattern
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: load_geometry(12'd128, 12'd64, 12'd16, 12'd4, 12'd2, 12'd0, 12'd0);
        1: load_geometry(12'd1, 12'd8, 12'd1, 12'd1, 12'd1, 12'd0, 12'd0);
        2: load_geometry(12'd128, 12'd64, 12'd4095, 12'd4095, 12'd512, 12'd4095, 12'd4095);
        3: load_geometry(12'd127, 12'd64, 12'd4095, 12'd2, 12'd1023, 12'd100, 12'd60);
        default: begin
          dw = int'($urandom_range(1, 128));
          dh = 8 * int'($urandom_range(1, 8));
          iw = int'($urandom_range(1, 64));
          ih = int'($urandom_range(1, 8));
          load_geometry(12'(dw), 12'(dh), 12'(iw), 12'(ih),
                        12'((iw + 7) / 8 + int'($urandom_range(0, 2))),
                        12'($urandom_range(0, dw)), 12'($urandom_range(0, dh)));
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      // Hold the reply side off so the block backs up into its input
      if (p == 4) hold_left = 300;
      repeat (100) random_cmd();
    end

    settle();
    if (sb.reply_queue.size() != 0) begin
      $display("%0d replies never arrived", sb.reply_queue.size());
      sb.mismatches += sb.reply_queue.size();
    end
    if (sb.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog for a hung block
  initial begin
    #12_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
